FILE: src/golden_angle_spiral_point_generator_core_assert.svh
// Assertion macros for the spiral point generator
`ifndef GOLDEN_ANGLE_SPIRAL_POINT_GENERATOR_CORE_ASSERT_SVH
`define GOLDEN_ANGLE_SPIRAL_POINT_GENERATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GASP_ASSERT_IMM(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define GASP_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define GASP_ASSERT_IMM(lbl, pre, post, msg)
`define GASP_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

FILE: src/gasp_pkg.sv
// Shared constants, types and tables of the spiral point generator
`timescale 1ns / 1ps
package gasp_pkg;
    localparam int MAX_POINTS   = 1024;
    localparam int ANGLE_BITS   = 24;
    localparam int COORD_BITS   = 12;
    localparam int IDX_W        = 10;
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_W       = 4;
    localparam int LOG_STEPS    = 16;
    localparam int DIV_STEPS    = 42;
    localparam int SQRT_STEPS   = 16;
    localparam int STEP_W       = 6;

    localparam logic [31:0] GOLD_Q32 = 32'h61C8_8647;
    localparam logic [ANGLE_BITS-1:0] GOLD_STEP =
        ANGLE_BITS'((((64'(GOLD_Q32) << 1) >> (32 - ANGLE_BITS)) + 64'd1) >> 1);
    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

    localparam logic [IDX_W-1:0] RST_POINT_COUNT   = 10'd256;
    localparam logic [12:0]      RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [12:0]      RST_SCREEN_HEIGHT = 13'd768;

    localparam logic [2:0] MODE_LINEAR  = 3'd0;
    localparam logic [2:0] MODE_LOG     = 3'd1;
    localparam logic [2:0] MODE_SQUARE  = 3'd2;
    localparam logic [2:0] MODE_INVERSE = 3'd3;
    localparam logic [2:0] MODE_SQRT    = 3'd4;

    localparam logic [3:0] COLOUR_LAST = 4'd13;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] cnt;
        logic [2:0]       mode;
    } rad_req_t;

    typedef enum logic [2:0] {R_IDLE, R_LOGN, R_LOGI, R_DIV, R_SQRT} rad_state_t;
    typedef enum logic [0:0] {C_IDLE, C_ITER} cor_state_t;
    typedef enum logic [2:0] {
        T_IDLE, T_START, T_CALC, T_RH, T_MX, T_PX, T_MY, T_PY
    } top_state_t;

    function automatic logic signed [32:0] atan_turn(input logic [ITER_W-1:0] k);
        logic signed [32:0] v;
        case (k)
            4'd0:    v = 33'sd536870912;
            4'd1:    v = 33'sd316933406;
            4'd2:    v = 33'sd167458907;
            4'd3:    v = 33'sd85004756;
            4'd4:    v = 33'sd42667331;
            4'd5:    v = 33'sd21354465;
            4'd6:    v = 33'sd10679838;
            4'd7:    v = 33'sd5340245;
            4'd8:    v = 33'sd2670163;
            4'd9:    v = 33'sd1335087;
            4'd10:   v = 33'sd667544;
            4'd11:   v = 33'sd333772;
            4'd12:   v = 33'sd166886;
            4'd13:   v = 33'sd83443;
            4'd14:   v = 33'sd41722;
            default: v = 33'sd20861;
        endcase
        return v;
    endfunction
endpackage

FILE: src/gasp_if.sv
// Request and point channel interfaces
`timescale 1ns / 1ps
interface gasp_req_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface gasp_pnt_if;
    import gasp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
    logic [3:0]            colour_code;
    logic [IDX_W-1:0]      point_number;
    logic                  last;
    modport source (output valid, output x_pos, output y_pos, output colour_code,
                    output point_number, output last, input ready);
    modport sink (input valid, input x_pos, input y_pos, input colour_code,
                  input point_number, input last, output ready);
endinterface

FILE: src/gasp_radius.sv
// Radius fraction unit: serial log2, restoring divider and square root
`timescale 1ns / 1ps
module gasp_radius (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gasp_pkg::rad_req_t req,
    output logic              busy,
    output logic [16:0]       radius
);
    import gasp_pkg::*;

    rad_state_t         st_reg, st_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [2:0]         mode_reg, mode_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [30:0]        m_reg, m_next;
    logic [3:0]         e_reg, e_next;
    logic [15:0]        frac_reg, frac_next;
    logic [19:0]        ln_reg, ln_next;
    logic [41:0]        num_reg, num_next;
    logic [19:0]        den_reg, den_next;
    logic [19:0]        rem_reg, rem_next;
    logic [31:0]        sv_reg, sv_next;
    logic [17:0]        srem_reg, srem_next;
    logic [15:0]        root_reg, root_next;
    logic [16:0]        r_reg, r_next;

    logic [61:0] msq;
    logic [31:0] sq;
    logic        lbit;
    logic [30:0] m_step;
    logic [15:0] frac_step;
    logic [20:0] dsh;
    logic        dge;
    logic [19:0] rem_step;
    logic [41:0] num_step;
    logic [19:0] st_t;
    logic [19:0] st_trial;
    logic        sge;
    logic [17:0] srem_step;
    logic [15:0] root_step;
    logic [34:0] lg_init;

    function automatic logic [34:0] log_init(input logic [IDX_W-1:0] x);
        logic [3:0] e;
        e = 4'd0;
        for (int k = 1; k < IDX_W; k++)
        begin
            if (x[k])
            begin
                e = 4'(k);
            end
        end
        return {e, 31'(x) << (5'd30 - {1'b0, e})};
    endfunction

    function automatic logic [16:0] clamp_r(input logic [41:0] q);
        return (q > 42'd65536) ? 17'd65536 : q[16:0];
    endfunction

    assign msq       = {31'b0, m_reg} * {31'b0, m_reg};
    assign sq        = msq[61:30];
    assign lbit      = sq[31];
    assign m_step    = lbit ? sq[31:1] : sq[30:0];
    assign frac_step = {frac_reg[14:0], lbit};

    assign dsh      = {rem_reg, num_reg[41]};
    assign dge      = dsh >= {1'b0, den_reg};
    assign rem_step = dge ? 20'(dsh - {1'b0, den_reg}) : dsh[19:0];
    assign num_step = {num_reg[40:0], dge};

    assign st_t      = {srem_reg, sv_reg[31:30]};
    assign st_trial  = {2'b00, root_reg, 2'b01};
    assign sge       = st_t >= st_trial;
    assign srem_step = sge ? 18'(st_t - st_trial) : st_t[17:0];
    assign root_step = {root_reg[14:0], sge};

    assign busy   = (st_reg != R_IDLE);
    assign radius = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= R_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        mode_reg <= mode_next;
        idx_reg  <= idx_next;
        m_reg    <= m_next;
        e_reg    <= e_next;
        frac_reg <= frac_next;
        ln_reg   <= ln_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        sv_reg   <= sv_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        r_reg    <= r_next;
    end

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        idx_next  = idx_reg;
        m_next    = m_reg;
        e_next    = e_reg;
        frac_next = frac_reg;
        ln_next   = ln_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        sv_next   = sv_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        r_next    = r_reg;
        lg_init   = log_init(idx_reg);
        case (st_reg)
            R_IDLE:
            begin
                lg_init = log_init(req.cnt);
                if (start)
                begin
                    mode_next = req.mode;
                    idx_next  = req.idx;
                    cnt_next  = '0;
                    rem_next  = '0;
                    if (req.cnt <= 10'd1 || (req.mode == MODE_LOG && req.idx == '0))
                    begin
                        r_next = '0;
                    end
                    else if (req.mode == MODE_LOG)
                    begin
                        e_next    = lg_init[34:31];
                        m_next    = lg_init[30:0];
                        frac_next = '0;
                        st_next   = R_LOGN;
                    end
                    else if (req.mode == MODE_SQUARE)
                    begin
                        num_next = {6'b0, 20'({10'b0, req.idx} * {10'b0, req.idx}), 16'b0};
                        den_next = 20'({10'b0, req.cnt} * {10'b0, req.cnt});
                        st_next  = R_DIV;
                    end
                    else if (req.mode == MODE_SQRT)
                    begin
                        num_next = {req.idx, 32'b0};
                        den_next = {10'b0, req.cnt};
                        st_next  = R_DIV;
                    end
                    else
                    begin
                        num_next = {16'b0, req.idx, 16'b0};
                        den_next = {10'b0, req.cnt};
                        st_next  = R_DIV;
                    end
                end
            end
            R_LOGN:
            begin
                m_next    = m_step;
                frac_next = frac_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(LOG_STEPS - 1))
                begin
                    ln_next   = {e_reg, frac_step};
                    e_next    = lg_init[34:31];
                    m_next    = lg_init[30:0];
                    frac_next = '0;
                    cnt_next  = '0;
                    st_next   = R_LOGI;
                end
            end
            R_LOGI:
            begin
                m_next    = m_step;
                frac_next = frac_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(LOG_STEPS - 1))
                begin
                    num_next = {6'b0, e_reg, frac_step, 16'b0};
                    den_next = ln_reg;
                    cnt_next = '0;
                    st_next  = R_DIV;
                end
            end
            R_DIV:
            begin
                num_next = num_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    cnt_next = '0;
                    if (mode_reg == MODE_SQRT)
                    begin
                        sv_next   = num_step[31:0];
                        srem_next = '0;
                        root_next = '0;
                        st_next   = R_SQRT;
                    end
                    else
                    begin
                        r_next  = clamp_r(num_step);
                        st_next = R_IDLE;
                    end
                end
            end
            R_SQRT:
            begin
                srem_next = srem_step;
                root_next = root_step;
                sv_next   = {sv_reg[29:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    r_next  = {1'b0, root_step};
                    st_next = R_IDLE;
                end
            end
            default:
            begin
                st_next = R_IDLE;
            end
        endcase
    end
endmodule

FILE: src/gasp_cordic.sv
// Iterative CORDIC giving cos and sin of a turn angle
`timescale 1ns / 1ps
module gasp_cordic (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [gasp_pkg::ANGLE_BITS-1:0] angle,
    output logic                           busy,
    output logic signed [31:0]             cos_v,
    output logic signed [31:0]             sin_v
);
    import gasp_pkg::*;

    cor_state_t          st_reg, st_next;
    logic [ITER_W-1:0]   k_reg, k_next;
    logic [1:0]          q_reg, q_next;
    logic signed [32:0]  x_reg, x_next;
    logic signed [32:0]  y_reg, y_next;
    logic signed [32:0]  z_reg, z_next;
    logic signed [31:0]  c_reg, c_next;
    logic signed [31:0]  s_reg, s_next;

    logic [31:0]        a32;
    logic [31:0]        asum;
    logic [31:0]        rz;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [32:0] xn;
    logic signed [32:0] yn;

    assign a32   = 32'(angle) << (32 - ANGLE_BITS);
    assign asum  = a32 + 32'h2000_0000;
    assign rz    = a32 - {asum[31:30], 30'b0};
    assign xs    = x_reg >>> k_reg;
    assign ys    = y_reg >>> k_reg;
    assign xn    = z_reg[32] ? (x_reg + ys) : (x_reg - ys);
    assign yn    = z_reg[32] ? (y_reg - xs) : (y_reg + xs);
    assign busy  = (st_reg != C_IDLE);
    assign cos_v = c_reg;
    assign sin_v = s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= C_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        q_reg <= q_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        c_reg <= c_next;
        s_reg <= s_next;
    end

    always_comb
    begin
        st_next = st_reg;
        k_next  = k_reg;
        q_next  = q_reg;
        x_next  = x_reg;
        y_next  = y_reg;
        z_next  = z_reg;
        c_next  = c_reg;
        s_next  = s_reg;
        case (st_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    q_next  = asum[31:30];
                    z_next  = {rz[31], rz};
                    x_next  = CORDIC_K;
                    y_next  = '0;
                    k_next  = '0;
                    st_next = C_ITER;
                end
            end
            C_ITER:
            begin
                x_next = xn;
                y_next = yn;
                z_next = z_reg[32] ? (z_reg + atan_turn(k_reg))
                                   : (z_reg - atan_turn(k_reg));
                k_next = k_reg + 1'b1;
                if (k_reg == ITER_W'(CORDIC_ITERS - 1))
                begin
                    case (q_reg)
                        2'd0:
                        begin
                            c_next = xn[31:0];
                            s_next = yn[31:0];
                        end
                        2'd1:
                        begin
                            c_next = 32'(-yn);
                            s_next = xn[31:0];
                        end
                        2'd2:
                        begin
                            c_next = 32'(-xn);
                            s_next = 32'(-yn);
                        end
                        default:
                        begin
                            c_next = yn[31:0];
                            s_next = 32'(-xn);
                        end
                    endcase
                    st_next = C_IDLE;
                end
            end
            default:
            begin
                st_next = C_IDLE;
            end
        endcase
    end
endmodule

FILE: src/golden_angle_spiral_point_generator_core.sv
// Golden-angle spiral point generator, top level
// One item in flight. Linear, square and inverse modes use the bit-serial divider
// (42 steps); square root mode adds the two-bit square root (16 steps) after it, and
// log mode adds two 16-step log passes ahead of the divider.
// The 16-step CORDIC runs beside the radius unit; placement follows in T_RH to T_PY.
// A finished point waits in the output register while the next item is taken.
// Reset loads the default configuration and clears point index and angle.
`timescale 1ns / 1ps
`include "golden_angle_spiral_point_generator_core_assert.svh"
module golden_angle_spiral_point_generator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    gasp_req_if.sink                       req_ch,
    gasp_pnt_if.source                     pnt_ch,
    input  logic                           cfg_we,
    input  logic [gasp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gasp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gasp_pkg::*;

    localparam logic [IDX_W-1:0] CNT_MAX = IDX_W'(MAX_POINTS - 1);
    localparam logic [12:0] COORD_MAX = 13'((1 << COORD_BITS) - 1);

    logic [IDX_W-1:0] pcount_reg;
    logic [2:0]       rmode_reg;
    logic [12:0]      swidth_reg;
    logic [12:0]      sheight_reg;

    top_state_t            st_reg, st_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [ANGLE_BITS-1:0] ang_reg, ang_next;
    logic [3:0]            col_reg, col_next;
    logic [IDX_W-1:0]      job_idx_reg, job_idx_next;
    logic [IDX_W-1:0]      job_n_reg, job_n_next;
    logic [ANGLE_BITS-1:0] job_ang_reg, job_ang_next;
    logic [3:0]            job_col_reg, job_col_next;
    logic                  job_last_reg, job_last_next;
    logic signed [30:0]    rh_reg, rh_next;
    logic signed [62:0]    prod_reg, prod_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic                  ov_reg, ov_next;
    logic [COORD_BITS-1:0] ox_reg, ox_next;
    logic [COORD_BITS-1:0] oy_reg, oy_next;
    logic [3:0]            oc_reg, oc_next;
    logic [IDX_W-1:0]      on_reg, on_next;
    logic                  ol_reg, ol_next;

    logic [IDX_W-1:0]   n_eff;
    logic               clr;
    logic [IDX_W-1:0]   i_cur;
    logic [3:0]         c_cur;
    logic               last_cur;
    logic               start;
    logic               rad_busy;
    logic               cor_busy;
    logic [16:0]        rad_r;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    logic signed [12:0] half;
    rad_req_t           rreq;
    logic               req_acc;
    logic               x_in_range;
    logic               colour_ok;

    function automatic logic [COORD_BITS-1:0] place_coord(input logic signed [62:0] p,
                                                          input logic [12:0] extent);
        logic [62:0]        mag;
        logic signed [18:0] off;
        logic signed [18:0] v;
        logic [12:0]        hi;
        mag = p[62] ? 63'(-p) : p;
        off = p[62] ? -$signed({2'b00, mag[62:46]}) : $signed({2'b00, mag[62:46]});
        v   = off + $signed({7'b0, extent[12:1]});
        if (extent == '0)
        begin
            hi = '0;
        end
        else if (13'(extent - 1'b1) > COORD_MAX)
        begin
            hi = COORD_MAX;
        end
        else
        begin
            hi = 13'(extent - 1'b1);
        end
        if (v < 0)
        begin
            return '0;
        end
        else if (v > $signed({6'b0, hi}))
        begin
            return COORD_BITS'(hi);
        end
        return COORD_BITS'(v);
    endfunction

    assign n_eff = (pcount_reg == '0) ? IDX_W'(1) :
                   ((pcount_reg > CNT_MAX) ? CNT_MAX : pcount_reg);
    assign half  = $signed({1'b0, sheight_reg[12:1]}) - 13'sd1;

    assign rreq.idx  = job_idx_reg;
    assign rreq.cnt  = job_n_reg;
    assign rreq.mode = rmode_reg;

    gasp_radius u_radius (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (rreq),
        .busy   (rad_busy),
        .radius (rad_r)
    );

    gasp_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .angle (job_ang_reg),
        .busy  (cor_busy),
        .cos_v (cos_v),
        .sin_v (sin_v)
    );

    assign pnt_ch.valid        = ov_reg;
    assign pnt_ch.x_pos        = ox_reg;
    assign pnt_ch.y_pos        = oy_reg;
    assign pnt_ch.colour_code  = oc_reg;
    assign pnt_ch.point_number = on_reg;
    assign pnt_ch.last         = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg  <= RST_POINT_COUNT;
            rmode_reg   <= MODE_LINEAR;
            swidth_reg  <= RST_SCREEN_WIDTH;
            sheight_reg <= RST_SCREEN_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POINT_COUNT:  pcount_reg  <= cfg_data[IDX_W-1:0];
                REG_RADIUS_MODE:  rmode_reg   <= cfg_data[2:0];
                REG_SCREEN_WIDTH: swidth_reg  <= cfg_data;
                default:          sheight_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= T_IDLE;
            idx_reg <= '0;
            ang_reg <= '0;
            col_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            ang_reg <= ang_next;
            col_reg <= col_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_idx_reg  <= job_idx_next;
        job_n_reg    <= job_n_next;
        job_ang_reg  <= job_ang_next;
        job_col_reg  <= job_col_next;
        job_last_reg <= job_last_next;
        rh_reg       <= rh_next;
        prod_reg     <= prod_next;
        px_reg       <= px_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        oc_reg       <= oc_next;
        on_reg       <= on_next;
        ol_reg       <= ol_next;
    end

    always_comb
    begin
        st_next       = st_reg;
        idx_next      = idx_reg;
        ang_next      = ang_reg;
        col_next      = col_reg;
        job_idx_next  = job_idx_reg;
        job_n_next    = job_n_reg;
        job_ang_next  = job_ang_reg;
        job_col_next  = job_col_reg;
        job_last_next = job_last_reg;
        rh_next       = rh_reg;
        prod_next     = prod_reg;
        px_next       = px_reg;
        ov_next       = ov_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oc_next       = oc_reg;
        on_next       = on_reg;
        ol_next       = ol_reg;
        req_ch.ready  = 1'b0;
        start         = 1'b0;
        clr           = req_ch.restart || (idx_reg >= n_eff);
        i_cur         = clr ? '0 : idx_reg;
        c_cur         = clr ? '0 : col_reg;
        last_cur      = (i_cur == IDX_W'(n_eff - 1'b1));

        if (ov_reg && pnt_ch.ready)
        begin
            ov_next = 1'b0;
        end

        case (st_reg)
            T_IDLE:
            begin
                req_ch.ready = 1'b1;
                if (req_ch.valid)
                begin
                    job_idx_next  = i_cur;
                    job_n_next    = n_eff;
                    job_ang_next  = (clr ? '0 : ang_reg) + GOLD_STEP;
                    job_col_next  = c_cur;
                    job_last_next = last_cur;
                    if (last_cur)
                    begin
                        idx_next = '0;
                        ang_next = '0;
                        col_next = '0;
                    end
                    else
                    begin
                        idx_next = i_cur + 1'b1;
                        ang_next = (clr ? '0 : ang_reg) + GOLD_STEP;
                        col_next = (c_cur == COLOUR_LAST) ? '0 : c_cur + 1'b1;
                    end
                    st_next = T_START;
                end
            end
            T_START:
            begin
                start   = 1'b1;
                st_next = T_CALC;
            end
            T_CALC:
            begin
                if (!rad_busy && !cor_busy)
                begin
                    st_next = T_RH;
                end
            end
            T_RH:
            begin
                rh_next = $signed({14'b0, rad_r}) * $signed({{18{half[12]}}, half});
                st_next = T_MX;
            end
            T_MX:
            begin
                prod_next = $signed({{32{rh_reg[30]}}, rh_reg}) *
                            $signed({{31{cos_v[31]}}, cos_v});
                st_next   = T_PX;
            end
            T_PX:
            begin
                px_next   = place_coord(prod_reg, swidth_reg);
                st_next   = T_MY;
            end
            T_MY:
            begin
                prod_next = $signed({{32{rh_reg[30]}}, rh_reg}) *
                            $signed({{31{sin_v[31]}}, sin_v});
                st_next   = T_PY;
            end
            T_PY:
            begin
                if (!ov_reg || pnt_ch.ready)
                begin
                    ov_next = 1'b1;
                    ox_next = px_reg;
                    oy_next = place_coord(prod_reg, sheight_reg);
                    oc_next = job_col_reg + 1'b1;
                    on_next = job_idx_reg;
                    ol_next = job_last_reg;
                    st_next = T_IDLE;
                end
            end
            default:
            begin
                st_next = T_IDLE;
            end
        endcase
    end

    assign req_acc    = req_ch.valid && req_ch.ready;
    assign x_in_range = (swidth_reg == '0) || ({1'b0, pnt_ch.x_pos} < swidth_reg);
    assign colour_ok  = (pnt_ch.colour_code >= 4'd1) && (pnt_ch.colour_code <= 4'd14);

    `GASP_ASSERT_NXT(a_busy_after_accept, req_acc, !req_ch.ready, "item taken while busy")
    `GASP_ASSERT_IMM(a_x_on_screen, pnt_ch.valid, x_in_range, "x position beyond screen width")
    `GASP_ASSERT_IMM(a_colour_range, pnt_ch.valid, colour_ok, "colour code out of palette")
endmodule

FILE: sim/golden_angle_spiral_point_generator_core_tb.sv
// Testbench for the golden-angle spiral point generator: predicts and checks every point
`timescale 1ns / 1ps
module golden_angle_spiral_point_generator_core_tb;
    import gasp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint TRIG_GAIN = 652032874;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_pos;
        logic [COORD_BITS-1:0] y_pos;
        logic [3:0]            colour_code;
        logic [IDX_W-1:0]      point_number;
        logic                  last;
    } point_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gasp_req_if req_ch ();
    gasp_pnt_if pnt_ch ();

    golden_angle_spiral_point_generator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch.sink),
        .pnt_ch    (pnt_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the block
    logic [9:0]            count_reg;
    logic [2:0]            mode_reg;
    logic [12:0]           width_reg;
    logic [12:0]           height_reg;
    int                    spiral_index;
    logic [ANGLE_BITS-1:0] spiral_angle;

    point_t expected_points[$];
    int     error_count;
    int     points_checked;
    int     points_sent;
    int     last_seen;
    int     idle_cycles;

    longint arc_table[CORDIC_ITERS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861
    };

    function automatic logic [63:0] log2_fixed(input logic [31:0] v);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        while (e < 31 && (v >> (e + 1)) != 0)
            e++;
        m = 64'(v) << (30 - e);
        frac = 0;
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(e) << 16) | frac;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] radius_fraction(input logic [63:0] i, input logic [63:0] n);
        logic [63:0] r;
        if (n <= 1)
            return 0;
        case (mode_reg)
            MODE_LOG:
            begin
                if (i == 0)
                    return 0;
                r = (log2_fixed(32'(i)) << 16) / log2_fixed(32'(n));
            end
            MODE_SQUARE: r = ((i * i) << 16) / (n * n);
            MODE_SQRT:   r = int_sqrt((i << 32) / n);
            default:     r = (i << 16) / n;
        endcase
        return (r > 65536) ? 64'd65536 : r;
    endfunction

    task automatic rotate(input logic [ANGLE_BITS-1:0] ang, output longint c, output longint s);
        logic [31:0] a32;
        logic [31:0] q;
        logic [31:0] rz;
        longint      z;
        longint      x;
        longint      y;
        longint      nx;
        a32 = {ang, {(32 - ANGLE_BITS){1'b0}}};
        q = (a32 + 32'h2000_0000) >> 30;
        rz = a32 - (q << 30);
        z = longint'($signed(rz));
        x = TRIG_GAIN;
        y = 0;
        for (int k = 0; k < CORDIC_ITERS; k++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> k);
                y = y + (x >>> k);
                z = z - arc_table[k];
            end
            else
            begin
                nx = x + (y >>> k);
                y = y - (x >>> k);
                z = z + arc_table[k];
            end
            x = nx;
        end
        case (q[1:0])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endtask

    function automatic logic [COORD_BITS-1:0] place_coord(input longint r, input longint trig,
        input longint half, input longint centre, input longint extent);
        longint p;
        longint off;
        longint v;
        longint hi;
        p = r * trig * half;
        off = (p < 0) ? -((-p) >> 46) : (p >> 46);
        v = off + centre;
        hi = extent - 1;
        if (hi > (1 << COORD_BITS) - 1)
            hi = (1 << COORD_BITS) - 1;
        if (hi < 0)
            hi = 0;
        if (v < 0)
            v = 0;
        if (v > hi)
            v = hi;
        return COORD_BITS'(v);
    endfunction

    task automatic next_spiral_point(input logic restart, output point_t pt);
        int          n;
        int          i;
        longint      r;
        longint      c;
        longint      s;
        longint      half;
        logic [63:0] step;
        n = (count_reg == 0) ? 1 : int'(count_reg);
        if (n > MAX_POINTS - 1)
            n = MAX_POINTS - 1;
        if (restart || spiral_index >= n)
        begin
            spiral_index = 0;
            spiral_angle = 0;
        end
        step = ((64'(GOLD_Q32) >> (32 - ANGLE_BITS - 1)) + 64'd1) >> 1;
        spiral_angle = spiral_angle + ANGLE_BITS'(step);
        i = spiral_index;
        r = longint'(radius_fraction(64'(i), 64'(n)));
        rotate(spiral_angle, c, s);
        half = longint'(height_reg / 2) - 1;
        pt.x_pos = place_coord(r, c, half, longint'(width_reg / 2), longint'(width_reg));
        pt.y_pos = place_coord(r, s, half, longint'(height_reg / 2), longint'(height_reg));
        pt.colour_code = 4'(i % 14 + 1);
        pt.point_number = IDX_W'(i);
        pt.last = (i == n - 1);
        if (pt.last)
        begin
            spiral_index = 0;
            spiral_angle = 0;
        end
        else
            spiral_index = (i + 1) % 1024;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls, with stretches of steady ready
    initial
    begin
        int run;
        pnt_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pnt_ch.ready <= 1'b1;
                repeat ($urandom_range(50, 400)) @(posedge clk);
            end
            run = random_gap();
            if (run > 0)
            begin
                pnt_ch.ready <= 1'b0;
                repeat (run) @(posedge clk);
            end
            pnt_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && pnt_ch.valid && pnt_ch.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected point x=%0d y=%0d num=%0d", $time,
                         pnt_ch.x_pos, pnt_ch.y_pos, pnt_ch.point_number);
                error_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                points_checked++;
                if (pnt_ch.last)
                    last_seen++;
                if (pnt_ch.x_pos !== want.x_pos)
                begin
                    $display("%0t: x_pos expected %0d actual %0d", $time, want.x_pos, pnt_ch.x_pos);
                    error_count++;
                end
                if (pnt_ch.y_pos !== want.y_pos)
                begin
                    $display("%0t: y_pos expected %0d actual %0d", $time, want.y_pos, pnt_ch.y_pos);
                    error_count++;
                end
                if (pnt_ch.colour_code !== want.colour_code)
                begin
                    $display("%0t: colour_code expected %0d actual %0d", $time,
                             want.colour_code, pnt_ch.colour_code);
                    error_count++;
                end
                if (pnt_ch.point_number !== want.point_number)
                begin
                    $display("%0t: point_number expected %0d actual %0d", $time,
                             want.point_number, pnt_ch.point_number);
                    error_count++;
                end
                if (pnt_ch.last !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last, pnt_ch.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (pnt_ch.valid && pnt_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d points outstanding", $time,
                     expected_points.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // called at a clock edge; leaves valid high after acceptance
    task automatic send_request(input logic restart, input int gap);
        point_t pt;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            req_ch.restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.restart <= restart;
        do
            @(posedge clk);
        while (!req_ch.ready);
        next_spiral_point(restart, pt);
        expected_points.push_back(pt);
        points_sent++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_POINT_COUNT:  count_reg = val[9:0];
            REG_RADIUS_MODE:  mode_reg = val[2:0];
            REG_SCREEN_WIDTH: width_reg = val;
            default:          height_reg = val;
        endcase
    endtask

    task automatic configure(input int pc, input int mode, input int w, input int h);
        drain();
        write_reg(REG_POINT_COUNT, CFG_DATA_W'(pc));
        write_reg(REG_RADIUS_MODE, CFG_DATA_W'(mode));
        write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(h));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_points(input int num, input int restart_pct);
        for (int k = 0; k < num; k++)
            send_request($urandom_range(0, 99) < restart_pct, random_gap());
    endtask

    task automatic test_defaults();
        send_request(1'b0, 0);
        send_request(1'b0, 0);
        send_request(1'b1, 1);
        run_points(3, 0);
    endtask

    task automatic test_each_mode();
        for (int m = 0; m < 8; m++)
        begin
            configure(5, m, 1024, 768);
            run_points(6, 0);
        end
    endtask

    task automatic test_edge_counts();
        configure(1, MODE_LINEAR, 640, 480);
        run_points(2, 0);
        configure(0, MODE_LOG, 640, 480);
        run_points(2, 0);
        configure(1023, MODE_SQRT, 8191, 8191);
        send_request(1'b1, 0);
        run_points(2, 0);
    endtask

    task automatic test_screen_extremes();
        configure(3, MODE_SQUARE, 16, 16);
        run_points(3, 0);
        configure(3, MODE_LINEAR, 4096, 4096);
        run_points(3, 0);
        configure(3, MODE_LINEAR, 16, 1);
        run_points(3, 0);
        configure(3, MODE_SQRT, 0, 0);
        run_points(3, 0);
    endtask

    task automatic test_count_lowered();
        configure(40, MODE_LINEAR, 800, 600);
        run_points(20, 0);
        configure(10, MODE_LINEAR, 800, 600);
        run_points(3, 0);
    endtask

    task automatic test_random_spirals();
        int pc;
        for (int phase = 0; phase < 20; phase++)
        begin
            if ($urandom_range(0, 4) == 0)
                pc = $urandom_range(0, 1023);
            else
                pc = $urandom_range(1, 40);
            configure(pc, $urandom_range(0, 7),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(16, 4096),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(16, 4096));
            run_points(50, 4);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_POINT_COUNT;
        cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.restart <= 1'b0;
        error_count = 0;
        points_checked = 0;
        points_sent = 0;
        last_seen = 0;
        count_reg = RST_POINT_COUNT;
        mode_reg = MODE_LINEAR;
        width_reg = RST_SCREEN_WIDTH;
        height_reg = RST_SCREEN_HEIGHT;
        spiral_index = 0;
        spiral_angle = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_each_mode();
        test_edge_counts();
        test_screen_extremes();
        test_count_lowered();
        test_random_spirals();

        drain();
        repeat (120) @(posedge clk);
        $display("Sent %0d requests, checked %0d points, %0d of them closing a spiral.",
                 points_sent, points_checked, last_seen);
        $display("Covered all radius modes, edge point counts and screen sizes, restarts.");
        if (error_count == 0 && expected_points.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
